// ===== sv/multichannel_oneshot_periodic_timer_macros.svh =====
// Assertion macros shared by the timer bank RTL.
// No dependencies; assertions drop out when SYNTHESIS is defined.
`ifndef MULTICHANNEL_ONESHOT_PERIODIC_TIMER_MACROS_SVH
`define MULTICHANNEL_ONESHOT_PERIODIC_TIMER_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define MOPT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define MOPT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define MOPT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MOPT_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/mopt_pkg.sv =====
// Package for the multichannel timer bank: sizes, codes and beat types.
// No dependencies.
`default_nettype none

package mopt_pkg;

	localparam int CHANNELS   = 8;
	localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int MASK_W     = 8;
	localparam int CHAN_FLD_W = 4;
	localparam int CNT_W      = 32;
	localparam int ENTRY_W    = 2 * CNT_W;

	typedef enum logic [1:0] {
		KIND_TICK  = 2'd0,
		KIND_START = 2'd1,
		KIND_STOP  = 2'd2,
		KIND_QUERY = 2'd3
	} kind_t;

	typedef enum logic [0:0] {
		REG_ENABLED   = 1'b0,
		REG_CONT_MASK = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic              enabled;
		logic [MASK_W-1:0] continuous_mask;
	} cfg_t;

	typedef struct packed {
		kind_t                 kind;
		logic [CHAN_FLD_W-1:0] channel;
		logic [CNT_W-1:0]      value;
	} cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] elapsed;
		logic [CNT_W-1:0] remaining;
		logic             active;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_DRAIN,
		ST_QUERY,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

// ===== sv/mopt_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module mopt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  wire logic                                      clk,
	input  wire logic                                      we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                          wdata,
	input  wire logic                                      re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== sv/mopt_ctrl.sv =====
// Timer bank sequencer: channel memory, running/valid flags, tick sweep and query.
// Depends on mopt_pkg, mopt_ram and the assertion macro header.
`default_nettype none
`include "multichannel_oneshot_periodic_timer_macros.svh"

module mopt_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire mopt_pkg::cfg_t cfg,
	input  wire logic           cmd_accept,
	input  wire mopt_pkg::cmd_t cmd,
	output logic                busy,
	output logic                res_valid,
	output mopt_pkg::res_t      res,
	input  wire logic           res_take
);
	import mopt_pkg::*;

	localparam logic [CHAN_FLD_W:0] CHAN_LIMIT = (CHAN_FLD_W + 1)'(CHANNELS);
	localparam logic [CH_W-1:0]     LAST_IDX   = CH_W'(CHANNELS - 1);

	state_t state_q, state_d;

	kind_t             kind_q;
	logic              in_range_q;
	logic [CH_W-1:0]   chan_q;
	logic [CH_W-1:0]   idx_q;
	logic              rd_vld_s1;
	logic [CH_W-1:0]   rd_idx_s1;
	logic [CHANNELS-1:0] running_q;
	logic [CHANNELS-1:0] valid_q;
	res_t              res_q;

	logic                ram_we, ram_re;
	logic [CH_W-1:0]     ram_waddr, ram_raddr;
	logic [ENTRY_W-1:0]  ram_wdata, ram_rdata;

	logic                cmd_in_range;
	logic [CH_W-1:0]     cmd_chan;
	logic                start_we, stop_hit, tick_we;
	logic [CHANNELS-1:0] cont_vec;
	logic [CNT_W-1:0]    rd_cnt, rd_tgt, cnt_inc, tick_cnt;
	logic                tick_hit, tick_stop;
	res_t                query_res;

	// channel memory: {target, counter} per channel
	mopt_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(CHANNELS)
	) u_chan_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// decode of the incoming beat
	assign cmd_in_range = {1'b0, cmd.channel} < CHAN_LIMIT;
	assign cmd_chan     = cmd.channel[CH_W-1:0];
	assign start_we = (state_q == ST_IDLE) && cmd_accept && (cmd.kind == KIND_START)
		&& cfg.enabled && cmd_in_range;
	assign stop_hit = (state_q == ST_IDLE) && cmd_accept && (cmd.kind == KIND_STOP)
		&& cmd_in_range;

	// continuous flag per channel; channels past the mask are one-shot
	always_comb begin
		for (int i = 0; i < CHANNELS; i++) begin
			cont_vec[i] = (i < MASK_W) ? cfg.continuous_mask[i % MASK_W] : 1'b0;
		end
	end

	// tick update of the entry read in the previous cycle
	assign rd_cnt    = ram_rdata[CNT_W-1:0];
	assign rd_tgt    = ram_rdata[ENTRY_W-1:CNT_W];
	assign cnt_inc   = rd_cnt + CNT_W'(1);
	assign tick_hit  = cnt_inc >= rd_tgt;
	assign tick_cnt  = (tick_hit && cont_vec[rd_idx_s1]) ? '0 : cnt_inc;
	assign tick_stop = tick_hit && !cont_vec[rd_idx_s1];
	assign tick_we   = rd_vld_s1 && running_q[rd_idx_s1];

	// query answer; an entry never started reads as zero
	always_comb begin
		logic [CNT_W-1:0] q_cnt;
		logic [CNT_W-1:0] q_tgt;
		q_cnt = valid_q[chan_q] ? rd_cnt : '0;
		q_tgt = valid_q[chan_q] ? rd_tgt : '0;
		query_res = '0;
		if (in_range_q) begin
			query_res.elapsed   = q_cnt;
			query_res.remaining = (q_cnt < q_tgt) ? (q_tgt - q_cnt) : '0;
			query_res.active    = running_q[chan_q];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_accept) begin
					unique case (cmd.kind)
						KIND_TICK:  state_d = ST_SWEEP;
						KIND_QUERY: state_d = ST_QUERY;
						KIND_START: state_d = ST_DONE;
						KIND_STOP:  state_d = ST_DONE;
					endcase
				end
			end
			ST_SWEEP: begin
				if (idx_q == LAST_IDX) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_DONE;
			ST_QUERY: state_d = ST_DONE;
			ST_DONE: begin
				if (res_take) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs and memory port control
	always_comb begin
		busy      = (state_q != ST_IDLE);
		res_valid = (state_q == ST_DONE);
		ram_re    = 1'b0;
		ram_raddr = cmd_chan;
		unique case (state_q)
			ST_IDLE: begin
				ram_re    = cmd_accept && (cmd.kind == KIND_QUERY);
				ram_raddr = cmd_chan;
			end
			ST_SWEEP: begin
				ram_re    = 1'b1;
				ram_raddr = idx_q;
			end
			default: begin
				ram_re = 1'b0;
			end
		endcase
		ram_we    = start_we || tick_we;
		ram_waddr = start_we ? cmd_chan : rd_idx_s1;
		ram_wdata = start_we ? {cmd.value, CNT_W'(0)} : {rd_tgt, tick_cnt};
	end

	assign res = res_q;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			idx_q     <= '0;
			rd_vld_s1 <= 1'b0;
			running_q <= '0;
			valid_q   <= '0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= (state_q == ST_SWEEP);
			if (state_q == ST_SWEEP) begin
				idx_q <= (idx_q == LAST_IDX) ? '0 : idx_q + CH_W'(1);
			end
			if (start_we) begin
				running_q[cmd_chan] <= 1'b1;
				valid_q[cmd_chan]   <= 1'b1;
			end
			if (stop_hit) begin
				running_q[cmd_chan] <= 1'b0;
			end
			if (tick_we && tick_stop) begin
				running_q[rd_idx_s1] <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		rd_idx_s1 <= idx_q;
		if ((state_q == ST_IDLE) && cmd_accept) begin
			kind_q     <= cmd.kind;
			in_range_q <= cmd_in_range;
			chan_q     <= cmd_chan;
			res_q      <= '0;
		end else if (state_q == ST_QUERY) begin
			res_q <= query_res;
		end
	end

	`MOPT_ASSERT_IMP(a_no_rw_clash, clk, arst_n, ram_we && ram_re, ram_waddr != ram_raddr)
	`MOPT_ASSERT_IMP(a_run_has_entry, clk, arst_n, 1'b1, (running_q & ~valid_q) == '0)
	`MOPT_ASSERT_IMP(a_nonquery_zero, clk, arst_n, (state_q == ST_DONE) && (kind_q != KIND_QUERY), res_q == '0)
	`MOPT_ASSERT_IMP(a_s1_in_sweep, clk, arst_n, rd_vld_s1, (state_q == ST_SWEEP) || (state_q == ST_DRAIN))
	`MOPT_ASSERT_NXT(a_sweep_ends, clk, arst_n, (state_q == ST_SWEEP) && (idx_q == LAST_IDX), state_q == ST_DRAIN)

endmodule

`default_nettype wire

// ===== sv/multichannel_oneshot_periodic_timer.sv =====
// Multichannel one-shot/periodic timer bank.
// Command channel (cmd_valid/cmd_stall, cmd) carries one tick, start, stop or query beat;
// every beat yields exactly one beat on the response channel (rsp_valid/rsp_stall, rsp).
// Only a query returns nonzero fields: elapsed count, remaining count, running flag.
// Configuration: cfg_we with cfg_index (enable, continuous mask) and cfg_wdata; write
// only while no command is in flight.
// Sequence per command: start and stop go straight to the done state; a query reads
// its entry in a query state; a tick sweeps the channel memory one entry per cycle
// through its single read port and one write port, then passes a drain state before
// done. Each answer is offered from the done state.
// One command is in flight at a time; cmd_stall is high while it runs.
// The response register frees the sequencer: a finished answer waits there while
// rsp_stall is high, and the sequencer holds a second answer until the register drains.
// Reset clears every channel's running and valid flags, the configuration and the response
// valid flag; unstarted channels read as zero, so no clearing pass over memory is needed.
// Depends on mopt_pkg and mopt_ctrl.
`default_nettype none

module multichannel_oneshot_periodic_timer (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cmd_valid,
	output logic                    cmd_stall,
	input  wire mopt_pkg::cmd_t     cmd,
	output logic                    rsp_valid,
	input  wire logic               rsp_stall,
	output mopt_pkg::res_t          rsp,
	input  wire logic               cfg_we,
	input  wire mopt_pkg::cfg_reg_t cfg_index,
	input  wire logic [mopt_pkg::MASK_W-1:0] cfg_wdata
);
	import mopt_pkg::*;

	cfg_t cfg_q;
	logic busy;
	logic cmd_accept;
	logic res_valid;
	res_t res;
	logic res_take;
	logic rsp_valid_q;
	res_t rsp_q;

	assign cmd_stall  = busy;
	assign cmd_accept = cmd_valid && !busy;
	assign res_take   = res_valid && (!rsp_valid_q || !rsp_stall);

	mopt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_accept(cmd_accept),
		.cmd       (cmd),
		.busy      (busy),
		.res_valid (res_valid),
		.res       (res),
		.res_take  (res_take)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ENABLED:   cfg_q.enabled         <= cfg_wdata[0];
				REG_CONT_MASK: cfg_q.continuous_mask <= cfg_wdata;
			endcase
		end
	end

	// response register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_take) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (res_take) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire
